// File: design/cbm_pkg.sv
// cbm_pkg: shared types and codes for the cartridge bank mapper
// item structs, target codes, register indexes and bank helper
// no dependencies
package cbm_pkg;

   // input item
   typedef struct packed {
      logic        operation;
      logic [15:0] address;
      logic [7:0]  write_data;
   } cbm_req_type;

   // result item
   typedef struct packed {
      logic [2:0]  target;
      logic [22:0] physical_address;
      logic [7:0]  ram_data;
   } cbm_rsp_type;

   // status from the remainder unit back to the sequencer
   typedef struct packed {
      logic       busy;
      logic       done;
      logic [6:0] remainder;
   } cbm_div_status_type;

   localparam int unsigned BANK_W  = 7;
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned CSR_IDX_W  = 2;

   // target codes
   localparam logic [2:0] TGT_NONE      = 3'd0;
   localparam logic [2:0] TGT_ROM_READ  = 3'd1;
   localparam logic [2:0] TGT_RAM_READ  = 3'd2;
   localparam logic [2:0] TGT_RAM_WRITE = 3'd3;
   localparam logic [2:0] TGT_READ_FF   = 3'd4;
   localparam logic [2:0] TGT_INVALID   = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CART_TYPE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BANK_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAM_SIZE   = 2'd2;

   // cartridge type codes
   localparam logic [1:0] CART_ROM_ONLY = 2'd0;

   // ram size codes
   localparam logic [2:0] RAM_NONE  = 3'd0;
   localparam logic [2:0] RAM_SMALL = 3'd1;
   localparam logic [2:0] RAM_FLAT  = 3'd2;

   // banks 0x00, 0x20, 0x40 and 0x60 step up to the next bank
   function automatic logic [BANK_W-1:0] skip_zero_bank(input logic [BANK_W-1:0] bank);
      logic [BANK_W-1:0] res;
      res = bank;
      if (bank[4:0] == 5'd0) begin
         res[0] = 1'b1;
      end
      return res;
   endfunction

endpackage

// File: design/cartridge_bank_mapper.sv
// cartridge_bank_mapper: banked cartridge address decoder and bank registers
// depends on cbm_pkg and cbm_rem_unit
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_item (cbm_req_type)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_item (cbm_rsp_type)
//   csr     | in        | csr_write_enable       | csr_index, csr_write_data
//
// one item at a time: accepted in idle; the result is registered and shown from
// the next cycle, except for a rom bank write that needs reduction, which goes
// through the remainder unit (one bit per cycle) and a collect step first
// while a result waits for rsp_ready no new item is taken
// synchronous active-high reset clears the bank registers and configuration
module cartridge_bank_mapper #(
   parameter int unsigned MAX_ROM_BANKS = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  cbm_pkg::cbm_req_type           req_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output cbm_pkg::cbm_rsp_type           rsp_item,
   input  logic                           csr_write_enable,
   input  logic [cbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import cbm_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_ROM_BANKS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type           state_ff, state_in;
   cbm_rsp_type         rsp_ff, rsp_in;
   logic [1:0]          cart_type_ff;
   logic [COUNT_W-1:0]  bank_count_ff;
   logic [2:0]          ram_code_ff;
   logic                ram_enabled_ff, ram_enabled_in;
   logic [BANK_W-1:0]   rom_bank_ff, rom_bank_in;
   logic [1:0]          upper_bits_ff, upper_bits_in;
   logic                bank_mode_ff, bank_mode_in;

   logic                accept;
   logic                div_start;
   logic [BANK_W-1:0]   raw_bank;
   logic [COUNT_W-1:0]  count_eff;
   cbm_div_status_type  div_status;
   logic [15:0]         addr;
   logic [15:0]         ram_offset;
   logic                in_ram_window;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_item  = rsp_ff;

   assign addr          = req_item.address;
   assign ram_offset    = addr - 16'hA000;
   assign in_ram_window = (addr >= 16'hA000) && (addr <= 16'hBFFF);

   // bank count clamped to the largest supported
   assign count_eff = (bank_count_ff > MAX_COUNT) ? MAX_COUNT : bank_count_ff;

   // new bank before reduction
   always_comb begin
      raw_bank = {2'b00, req_item.write_data[4:0]};
      if (!bank_mode_ff) begin
         raw_bank[6:5] = upper_bits_ff;
      end
   end

   cbm_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (raw_bank),
      .divisor  (count_eff),
      .status   (div_status)
   );

   // decode and sequencing
   always_comb begin
      state_in       = state_ff;
      rsp_in         = rsp_ff;
      ram_enabled_in = ram_enabled_ff;
      rom_bank_in    = rom_bank_ff;
      upper_bits_in  = upper_bits_ff;
      bank_mode_in   = bank_mode_ff;
      div_start      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in   = '0;
               state_in = ST_OUT;
               if (in_ram_window) begin
                  // cartridge ram window
                  if (!ram_enabled_ff || ram_code_ff == RAM_NONE
                      || (ram_code_ff == RAM_SMALL && addr > 16'hA7FF)) begin
                     rsp_in.target = req_item.operation ? TGT_NONE : TGT_READ_FF;
                  end else begin
                     if (ram_code_ff == RAM_SMALL || ram_code_ff == RAM_FLAT) begin
                        rsp_in.physical_address = {10'd0, ram_offset[12:0]};
                     end else begin
                        rsp_in.physical_address = {8'd0, upper_bits_ff, ram_offset[12:0]};
                     end
                     if (req_item.operation) begin
                        rsp_in.target   = TGT_RAM_WRITE;
                        rsp_in.ram_data = req_item.write_data;
                     end else begin
                        rsp_in.target = TGT_RAM_READ;
                     end
                  end
               end else if (!req_item.operation) begin
                  // rom reads
                  if (addr[15]) begin
                     rsp_in.target = TGT_INVALID;
                  end else begin
                     rsp_in.target = TGT_ROM_READ;
                     if (addr[14] && cart_type_ff != CART_ROM_ONLY) begin
                        rsp_in.physical_address = {2'b00, rom_bank_ff, addr[13:0]};
                     end else begin
                        rsp_in.physical_address = {7'd0, addr};
                     end
                  end
               end else if (addr[15]) begin
                  rsp_in.target = TGT_INVALID;
               end else if (cart_type_ff != CART_ROM_ONLY) begin
                  // banking register writes
                  case (addr[14:13])
                     2'b00: ram_enabled_in = |(req_item.write_data & 8'h0A);
                     2'b01: begin
                        if (count_eff != '0
                            && {{(COUNT_W-BANK_W){1'b0}}, raw_bank} > count_eff) begin
                           div_start = 1'b1;
                           state_in  = ST_DIV;
                        end else begin
                           rom_bank_in = skip_zero_bank(raw_bank);
                        end
                     end
                     2'b10: upper_bits_in = req_item.write_data[1:0];
                     2'b11: bank_mode_in  = req_item.write_data[0];
                     default: ;
                  endcase
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               rom_bank_in = skip_zero_bank(div_status.remainder);
               state_in    = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state, bank registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ram_enabled_ff <= 1'b0;
         rom_bank_ff    <= '0;
         upper_bits_ff  <= '0;
         bank_mode_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ram_enabled_ff <= ram_enabled_in;
         rom_bank_ff    <= rom_bank_in;
         upper_bits_ff  <= upper_bits_in;
         bank_mode_ff   <= bank_mode_in;
      end
      rsp_ff <= rsp_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff  <= '0;
         bank_count_ff <= '0;
         ram_code_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CART_TYPE:  cart_type_ff  <= csr_write_data[1:0];
            CSR_BANK_COUNT: bank_count_ff <= csr_write_data[COUNT_W-1:0];
            CSR_RAM_SIZE:   ram_code_ff   <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

endmodule

// File: design/cbm_rem_unit.sv
// cbm_rem_unit: iterative restoring remainder of a 7-bit bank by the bank count
// one quotient bit per cycle through a single subtract and compare
// depends on cbm_pkg
module cbm_rem_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cbm_pkg::BANK_W-1:0]  dividend,
   input  logic [cbm_pkg::COUNT_W-1:0] divisor,
   output cbm_pkg::cbm_div_status_type status
);
   import cbm_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [2:0]          step_ff, step_in;
   logic [BANK_W-1:0]   rem_ff, rem_in;
   logic [BANK_W-1:0]   num_ff, num_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [BANK_W:0]     trial;
   logic [COUNT_W-1:0]  trial_ext;
   logic [BANK_W:0]     diff;

   // shared subtract and compare
   assign trial     = {rem_ff, num_ff[BANK_W-1]};
   assign trial_ext = {{(COUNT_W-BANK_W-1){1'b0}}, trial};
   assign diff      = trial - div_ff[BANK_W:0];

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = 3'(BANK_W - 1);
         rem_in  = '0;
         num_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[BANK_W-2:0], 1'b0};
         if (trial_ext >= div_ff) begin
            rem_in = diff[BANK_W-1:0];
         end else begin
            rem_in = trial[BANK_W-1:0];
         end
         if (step_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
   end

   assign status.busy      = busy_ff;
   assign status.done      = done_ff;
   assign status.remainder = rem_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for cartridge_bank_mapper
// depends on cbm_pkg and the mapper rtl; keeps its own bank register model

module tb_top;
   import cbm_pkg::*;

   localparam int unsigned ROM_BANK_LIMIT = 512;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES  = 12;
   localparam int unsigned PHASE_ITEMS    = 128;

   localparam logic                 OP_READ       = 1'b0;
   localparam logic                 OP_WRITE      = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED    = 2'd3;

   // expected decodes, kept in step with the bank registers of the block
   class mapper_scoreboard;
      logic [1:0]  cart_type;
      logic [9:0]  bank_count;
      logic [2:0]  ram_code;
      logic        ram_on;
      logic [6:0]  rom_bank;
      logic [1:0]  upper_bits;
      logic        banking_mode;
      cbm_rsp_type expected_decodes[$];
      int unsigned failures;

      function new();
         cart_type    = '0;
         bank_count   = '0;
         ram_code     = '0;
         ram_on       = 1'b0;
         rom_bank     = '0;
         upper_bits   = '0;
         banking_mode = 1'b0;
         failures     = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CART_TYPE:  cart_type  = data[1:0];
            CSR_BANK_COUNT: bank_count = data[9:0];
            CSR_RAM_SIZE:   ram_code   = data[2:0];
            default: ;
         endcase
      endfunction

      // decode one accepted access and update the bank registers
      function void note_access(cbm_req_type acc);
         cbm_rsp_type res;
         int unsigned phys;
         int unsigned bank;
         int unsigned count;
         res = '0;
         if (acc.address >= 16'hA000 && acc.address <= 16'hBFFF) begin
            // cartridge ram window
            phys = 32'(acc.address) - 32'hA000;
            if (!ram_on || ram_code == RAM_NONE ||
                (ram_code == RAM_SMALL && acc.address > 16'hA7FF)) begin
               res.target = (acc.operation == OP_WRITE) ? TGT_NONE : TGT_READ_FF;
            end else begin
               // banked ram takes the upper bits whatever the mode
               if (ram_code != RAM_SMALL && ram_code != RAM_FLAT) begin
                  phys = phys + 32'(upper_bits) * 32'h2000;
               end
               res.physical_address = 23'(phys);
               if (acc.operation == OP_WRITE) begin
                  res.target   = TGT_RAM_WRITE;
                  res.ram_data = acc.write_data;
               end else begin
                  res.target = TGT_RAM_READ;
               end
            end
         end else if (acc.operation == OP_READ) begin
            // rom reads, fixed low half and switchable upper half
            if (acc.address < 16'h8000) begin
               res.target = TGT_ROM_READ;
               if (acc.address >= 16'h4000 && cart_type != CART_ROM_ONLY) begin
                  phys = 32'(rom_bank) * 32'h4000 + (32'(acc.address) - 32'h4000);
               end else begin
                  phys = 32'(acc.address);
               end
               res.physical_address = 23'(phys);
            end else begin
               res.target = TGT_INVALID;
            end
         end else if (acc.address < 16'h8000) begin
            // register writes, ignored on rom-only carts
            res.target = TGT_NONE;
            if (cart_type != CART_ROM_ONLY) begin
               if (acc.address < 16'h2000) begin
                  ram_on = (acc.write_data & 8'h0A) != 8'h00;
               end else if (acc.address < 16'h4000) begin
                  bank = banking_mode ? 32'(acc.write_data[4:0])
                                      : 32'({upper_bits, acc.write_data[4:0]});
                  count = (32'(bank_count) > ROM_BANK_LIMIT) ? ROM_BANK_LIMIT
                                                             : 32'(bank_count);
                  if (count != 0 && bank > count) begin
                     bank = bank % count;
                  end
                  if (bank == 32'h00 || bank == 32'h20 || bank == 32'h40 || bank == 32'h60) begin
                     bank = bank + 1;
                  end
                  rom_bank = 7'(bank);
               end else if (acc.address < 16'h6000) begin
                  upper_bits = acc.write_data[1:0];
               end else begin
                  banking_mode = acc.write_data[0];
               end
            end
         end else begin
            res.target = TGT_INVALID;
         end
         expected_decodes.push_back(res);
      endfunction

      function void check_result(cbm_rsp_type got);
         cbm_rsp_type want;
         if (expected_decodes.size() == 0) begin
            $display("%0t: result with nothing expected, expected none actual %h", $time, got);
            failures++;
            return;
         end
         want = expected_decodes.pop_front();
         if (got.target !== want.target) begin
            $display("%0t: target mismatch, expected %0d actual %0d",
                     $time, want.target, got.target);
            failures++;
         end
         if (got.physical_address !== want.physical_address) begin
            $display("%0t: physical_address mismatch, expected %h actual %h",
                     $time, want.physical_address, got.physical_address);
            failures++;
         end
         if (got.ram_data !== want.ram_data) begin
            $display("%0t: ram_data mismatch, expected %h actual %h",
                     $time, want.ram_data, got.ram_data);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   cbm_req_type           req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   cbm_rsp_type           rsp_item;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   int unsigned req_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned holdoff_cycles = 0;
   int unsigned stalled_cycles = 0;

   mapper_scoreboard sb = new();

   cartridge_bank_mapper #(
      .MAX_ROM_BANKS(ROM_BANK_LIMIT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side: random stalls, plus a long hold-off when asked for
   initial begin
      forever begin
         @(posedge clock);
         if (holdoff_cycles != 0) begin
            rsp_ready <= 1'b0;
            holdoff_cycles = holdoff_cycles - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // result checking and progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_item);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
            stalled_cycles = 0;
         end else begin
            stalled_cycles = stalled_cycles + 1;
         end
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no item moved for %0d cycles, %0d results outstanding",
                     $time, stalled_cycles, sb.expected_decodes.size());
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   function automatic cbm_req_type access(logic op, logic [15:0] addr, logic [7:0] data);
      cbm_req_type acc;
      acc.operation  = op;
      acc.address    = addr;
      acc.write_data = data;
      return acc;
   endfunction

   // mostly well-formed traffic: bank register writes, rom and ram accesses
   function automatic cbm_req_type random_access();
      cbm_req_type acc;
      int unsigned pick;
      pick = $urandom_range(99);
      acc.operation  = 1'($urandom_range(1));
      acc.write_data = 8'($urandom_range(255));
      acc.address    = '0;
      if (pick < 18) begin
         acc.operation = OP_WRITE;
         acc.address   = 16'($urandom_range(16'h7FFF));
         if (acc.address < 16'h2000 && $urandom_range(1) == 1) begin
            acc.write_data = 8'h0A;
         end else if (acc.address >= 16'h2000 && acc.address < 16'h4000 &&
                      $urandom_range(3) == 0) begin
            acc.write_data[4:0] = 5'd0;
         end
      end else if (pick < 38) begin
         acc.operation = OP_READ;
         acc.address   = 16'($urandom_range(16'h7FFF, 16'h4000));
      end else if (pick < 46) begin
         acc.operation = OP_READ;
         acc.address   = 16'($urandom_range(16'h3FFF));
      end else if (pick < 82) begin
         // ram window, with its edges and the small ram boundary now and then
         case ($urandom_range(7))
            0: acc.address = 16'hA7FF;
            1: acc.address = 16'hA800;
            2: acc.address = 16'hBFFF;
            3: acc.address = 16'hA000;
            default: acc.address = 16'($urandom_range(16'hBFFF, 16'hA000));
         endcase
      end else if ($urandom_range(1) == 1) begin
         acc.address = 16'($urandom_range(16'h9FFF, 16'h8000));
      end else begin
         acc.address = 16'($urandom_range(16'hFFFF, 16'hC000));
      end
      return acc;
   endfunction

   // offer one item, idling beforehand at the current sender rate
   task automatic send_access(input cbm_req_type acc);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= acc;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      sb.note_access(acc);
   endtask

   task automatic wait_all_results();
      while (sb.expected_decodes.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      sb.write_register(idx, data);
      @(posedge clock);
   endtask

   // all registers plus the unused index; spare upper bits carry junk
   task automatic configure_mapper(input logic [1:0] cart_type, input logic [9:0] count,
                                   input logic [2:0] ram_code);
      logic [7:0] junk;
      junk = 8'($urandom_range(255));
      write_csr(CSR_CART_TYPE, {junk, cart_type});
      write_csr(CSR_BANK_COUNT, count);
      write_csr(CSR_RAM_SIZE, {junk[6:0], ram_code});
      write_csr(CSR_UNUSED, {junk, 2'd3});
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [1:0] cart_type, input logic [9:0] count,
                            input logic [2:0] ram_code, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned holdoff);
      configure_mapper(cart_type, count, ram_code);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      holdoff_cycles = holdoff;
      repeat (PHASE_ITEMS) send_access(random_access());
      req_valid <= 1'b0;
      wait_all_results();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: rom-only cart, ram off
      send_access(access(OP_READ, 16'h0000, 8'h00));
      send_access(access(OP_READ, 16'h7FFF, 8'hFF));
      send_access(access(OP_WRITE, 16'h2000, 8'h05));
      send_access(access(OP_READ, 16'hA000, 8'h00));
      send_access(access(OP_WRITE, 16'hBFFF, 8'hA5));
      send_access(access(OP_READ, 16'hFFFF, 8'h00));
      send_access(access(OP_WRITE, 16'h8000, 8'h00));
      req_valid <= 1'b0;
      wait_all_results();

      // banked cart, eight banks, small ram
      configure_mapper(2'd1, 10'd8, RAM_SMALL);
      send_access(access(OP_WRITE, 16'h0000, 8'h0A));
      send_access(access(OP_WRITE, 16'h2000, 8'h00));
      send_access(access(OP_READ, 16'h4000, 8'h00));
      send_access(access(OP_WRITE, 16'h4000, 8'h03));
      send_access(access(OP_WRITE, 16'h2000, 8'h1F));
      send_access(access(OP_READ, 16'h7FFF, 8'h00));
      send_access(access(OP_WRITE, 16'h4000, 8'h00));
      // bank equal to the count stays as it is
      send_access(access(OP_WRITE, 16'h2000, 8'h08));
      send_access(access(OP_READ, 16'h4000, 8'h00));
      send_access(access(OP_READ, 16'hA7FF, 8'h00));
      send_access(access(OP_READ, 16'hA800, 8'h00));
      send_access(access(OP_WRITE, 16'hA800, 8'h11));
      send_access(access(OP_WRITE, 16'hA000, 8'hFF));
      send_access(access(OP_WRITE, 16'h6000, 8'hFF));
      send_access(access(OP_WRITE, 16'h1FFF, 8'hF5));
      send_access(access(OP_READ, 16'hA000, 8'h00));
      req_valid <= 1'b0;
      wait_all_results();

      // random phases over settings and idling patterns
      run_phase(2'd1, 10'd4, 3'd3, 0, 0, 300);
      run_phase(2'd3, 10'd512, 3'd5, 87, 0, 0);
      run_phase(2'd0, 10'd0, RAM_NONE, 0, 87, 0);
      run_phase(2'd2, 10'd1023, RAM_SMALL, 25, 25, 0);
      run_phase(2'd1, 10'd1, RAM_FLAT, 0, 0, 0);
      run_phase(2'd2, 10'd31, 3'd7, 87, 0, 0);
      run_phase(2'd3, 10'($urandom_range(130, 2)), 3'd4, 0, 87, 0);
      run_phase(2'd1, 10'd0, 3'd3, 25, 25, 0);

      if (sb.failures == 0 && sb.expected_decodes.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
